// ===== src/twrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrm_pkg
// Shared constants and control/status types of the time window running max.
// ----------------------------------------------------------------------------
package twrm_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned TIME_W  = 62;
  localparam int unsigned PRICE_W = 40;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned SPAN_W  = 42;
  localparam int unsigned CHG_W   = 32;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned NUM_W   = PRICE_W + FRAC_W;
  localparam int unsigned IN_W    = 104;
  localparam int unsigned OUT_W   = 80;

  localparam logic [25:0]       USEC_PER_MIN = 26'd60000000;
  localparam logic [WIN_W-1:0]  WIN_RESET    = 16'd120;
  localparam logic [CHG_W-1:0]  CHANGE_MAX   = 32'h7FFF_FFFF;
  localparam logic [CHG_W-1:0]  ONE_Q24      = 32'h0100_0000;
  localparam logic [NUM_W-1:0]  Q_LIMIT      = 64'h0000_0000_80FF_FFFF;

  typedef struct packed {
    logic accept;
    logic exp_pop;
    logic store;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic expired;
    logic scan_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== src/twrm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrm_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twrm_div import twrm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [PRICE_W-1:0] den_i,
  output logic               busy_o,
  output logic [NUM_W-1:0]   quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   num_q;
  logic [PRICE_W-1:0] rem_q, den_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PRICE_W:0]   rem_sh;
  logic [PRICE_W+1:0] diff;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_o) begin
      if (!diff[PRICE_W+1]) begin
        rem_q <= diff[PRICE_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[PRICE_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/twrm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrm_dp
// Datapath: sample store, pointers, expiry compare, max scan, change calc.
// ----------------------------------------------------------------------------
module twrm_dp import twrm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            sts_o,
  input  logic [IN_W-1:0]    in_data_i,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [OUT_W-1:0]   out_data_o
);

  logic [TIME_W-1:0]  time_mem [DEPTH];
  logic [PRICE_W-1:0] price_mem [DEPTH];

  logic [WIN_W-1:0]   win_q;
  logic [SPAN_W-1:0]  span_q;
  logic [TIME_W-1:0]  t_q, rd_time_q;
  logic [PRICE_W-1:0] p_q, rd_price_q, best_q, prev_max_q;
  logic [AW-1:0]      head_q, tail_q, scan_idx_q, rd_addr;
  logic [CW-1:0]      count_q, scan_cnt_q;
  logic               rd_vld_q, seen_q, drop_q, div_busy;
  logic               full, out_valid_q;
  logic [AW-1:0]      head_new;
  logic [CW-1:0]      count_new;
  logic [NUM_W-1:0]   quot;
  logic [CHG_W-1:0]   change;
  logic               chg_ovf;
  logic [OUT_W-1:0]   out_q;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    adv = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_q == CW'(DEPTH));
  assign head_new  = full ? adv(head_q) : head_q;
  assign count_new = full ? count_q : count_q + 1'b1;
  assign rd_addr   = cmd_i.scan ? scan_idx_q : head_q;

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.expired    = ({1'b0, rd_time_q} + {21'd0, span_q}) < {1'b0, t_q};
  assign sts_o.scan_done  = (scan_cnt_q == '0) && !rd_vld_q;
  assign sts_o.div_done   = !div_busy;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  twrm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.store && seen_q && (prev_max_q != '0)),
    .num_i   ({p_q, FRAC_W'(0)}),
    .den_i   (prev_max_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_comb begin
    change  = '0;
    chg_ovf = 1'b0;
    if (seen_q) begin
      if (prev_max_q == '0) begin
        chg_ovf = 1'b1;
        change  = (p_q != '0) ? CHANGE_MAX : '0;
      end else if (quot > Q_LIMIT) begin
        chg_ovf = 1'b1;
        change  = CHANGE_MAX;
      end else begin
        change  = quot[CHG_W-1:0] - ONE_Q24;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      time_mem[tail_q]  <= t_q;
      price_mem[tail_q] <= p_q;
    end
    rd_time_q  <= time_mem[rd_addr];
    rd_price_q <= price_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    span_q <= SPAN_W'(win_q) * SPAN_W'(USEC_PER_MIN);
    if (cmd_i.accept) begin
      t_q <= in_data_i[TIME_W-1:0];
      p_q <= in_data_i[TIME_W +: PRICE_W];
    end
    if (cmd_i.store) begin
      best_q <= '0;
    end else if (rd_vld_q && (rd_price_q > best_q)) begin
      best_q <= rd_price_q;
    end
    if (cmd_i.finish) begin
      out_q <= {6'd0, (drop_q | chg_ovf), seen_q, change, best_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      drop_q      <= 1'b0;
      prev_max_q  <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (cmd_i.exp_pop) begin
        head_q  <= adv(head_q);
        count_q <= count_q - 1'b1;
      end else if (cmd_i.store) begin
        head_q     <= head_new;
        count_q    <= count_new;
        tail_q     <= adv(tail_q);
        drop_q     <= full;
        scan_idx_q <= head_new;
        scan_cnt_q <= count_new;
      end
      if (cmd_i.store) begin
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan && (scan_cnt_q != '0)) begin
        rd_vld_q   <= 1'b1;
        scan_idx_q <= adv(scan_idx_q);
        scan_cnt_q <= scan_cnt_q - 1'b1;
      end else begin
        rd_vld_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        prev_max_q  <= best_q;
        seen_q      <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/twrm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twrm_ctrl
// Per-sample sequencer: expire, store, scan, divide, deliver.
// ----------------------------------------------------------------------------
module twrm_ctrl import twrm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXP_RD  = 7'b0000010,
    S_EXP_CHK = 7'b0000100,
    S_STORE   = 7'b0001000,
    S_SCAN    = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXP_RD;
        end
      end
      S_EXP_RD: begin
        if (sts_i.count_zero) begin
          state_d = S_STORE;
        end else begin
          state_d = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (sts_i.expired) begin
          cmd_o.exp_pop = 1'b1;
          state_d       = S_EXP_RD;
        end else begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/time_window_running_max_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_running_max_unit
// Running maximum of prices over a time window, with change against the
// previous maximum.
// ----------------------------------------------------------------------------
// One sample is processed at a time. The expiry walk reads each head entry
// and then checks it, popping the E entries that expire; the maximum is a
// scan of the N entries held after the store (up to 1024) at one entry per
// cycle through its single read port, and the 64-bit restoring divider for
// the change runs alongside the scan. The next sample is taken while a
// finished result still waits on the output register.
module time_window_running_max_unit import twrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // sample_time[61:0], sample_price[101:62]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // window_max[39:0], change[71:40],
                                           // change_valid[72], overflow[73]
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i     // window_minutes
);

  cmd_t    cmd;
  status_t sts;

  twrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  twrm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
